FILE: sv/ffha_pkg.sv
package ffha_pkg;

  localparam int ARENA_GRANULES = 1024;
  localparam int AW = $clog2(ARENA_GRANULES);
  localparam int MW = AW + 1;
  localparam int BW = MW + 1;
  localparam int CW = AW + 1;
  localparam int PW = AW + 2;
  localparam int FIELD_W = 10;
  localparam logic [AW-1:0] SENT = AW'(ARENA_GRANULES - 2);
  localparam logic [AW-1:0] SENT_LINK = AW'(ARENA_GRANULES - 1);
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE = 1'b1;

  typedef struct packed {
    logic               func;
    logic [FIELD_W-1:0] request_size;
    logic [FIELD_W-1:0] free_address;
  } ffha_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] payload_address;
    logic               ok;
  } ffha_out_t;

  typedef struct packed {
    logic          re;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] wdata;
  } ffha_a_req_t;

  typedef struct packed {
    logic          re;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [BW-1:0] wdata;
  } ffha_b_req_t;

  function automatic logic [AW-1:0] ffha_init_a(logic [AW-1:0] i);
    logic [AW-1:0] r;
    r = '0;
    if (i == AW'(0) || i == AW'(1)) begin
      r = SENT;
    end
    return r;
  endfunction

  function automatic logic [BW-1:0] ffha_init_b(logic [AW-1:0] i);
    logic [BW-1:0] r;
    r = '0;
    if (i == AW'(0)) begin
      r = {1'b0, MW'(ARENA_GRANULES - 3)};
    end else if (i == AW'(1)) begin
      r = {1'b0, 1'b0, SENT};
    end else if (i == SENT) begin
      r = {1'b1, MW'(1)};
    end
    return r;
  endfunction

endpackage

FILE: sv/ffha_ram.sv
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/ffha_seq.sv
module ffha_seq import ffha_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  ffha_in_t      req,
  output logic          idle,
  output ffha_a_req_t   a_req,
  output ffha_b_req_t   b_req,
  input  logic [AW-1:0] a_rdata,
  input  logic [BW-1:0] b_rdata,
  output logic          res_valid,
  input  logic          res_ready,
  output ffha_out_t     res
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] A_HEAD  = 5'd2;
  localparam logic [4:0] A_HEAD2 = 5'd3;
  localparam logic [4:0] A_CHK   = 5'd4;
  localparam logic [4:0] A_SIZE  = 5'd5;
  localparam logic [4:0] A_PREV  = 5'd6;
  localparam logic [4:0] F_WALK  = 5'd7;
  localparam logic [4:0] F_SIZE  = 5'd8;
  localparam logic [4:0] F_PHYS  = 5'd9;
  localparam logic [4:0] F_PSZ   = 5'd10;
  localparam logic [4:0] F_NSZ   = 5'd11;
  localparam logic [4:0] F_LINK  = 5'd12;
  localparam logic [4:0] F_HEAD  = 5'd13;
  localparam logic [4:0] S_WR    = 5'd14;
  localparam logic [4:0] S_FIN   = 5'd15;

  logic [4:0]    state_r;
  logic [AW-1:0] clr_r;
  logic [CW-1:0] cnt_r;
  logic [MW-1:0] req_r;
  logic [AW-1:0] cur_r, ln_r, blk_r, nb_r, pb_r;
  logic [PW-1:0] p_r;
  logic [MW-1:0] cs_r, s_r;
  logic [BW-1:0] ps_r, ns_r;
  ffha_out_t     res_r;
  logic [1:0]    qi_r;
  logic          qa_en_r [4];
  logic [AW-1:0] qa_addr_r [4];
  logic [AW-1:0] qa_data_r [4];
  logic          qb_en_r [4];
  logic [AW-1:0] qb_addr_r [4];
  logic [BW-1:0] qb_data_r [4];

  logic          b_free, b_used, fits, split;
  logic          pf, pu, nf, nu;
  logic [AW-1:0] t, ts_end, ms2_end, ms3_end;
  logic [MW-1:0] ts, ms2, ms3, sz1;

  assign b_free = !b_rdata[BW-1] && (b_rdata[MW-1:0] != '0);
  assign b_used = b_rdata[BW-1] && (b_rdata[MW-1:0] != '0);
  assign fits   = !b_rdata[BW-1] && (b_rdata[MW-1:0] >= req_r);
  assign split  = cs_r > (req_r + MW'(2));
  assign t      = cur_r + req_r[AW-1:0] + AW'(1);
  assign ts     = cs_r - req_r - MW'(1);
  assign ts_end = t + ts[AW-1:0] + AW'(1);
  assign pf     = !ps_r[BW-1] && (ps_r[MW-1:0] != '0);
  assign pu     = ps_r[BW-1] && (ps_r[MW-1:0] != '0);
  assign nf     = b_free;
  assign nu     = b_used;
  assign sz1    = ps_r[MW-1:0] + s_r + MW'(1);
  assign ms2    = s_r + ns_r[MW-1:0] + MW'(1);
  assign ms3    = ps_r[MW-1:0] + s_r + ns_r[MW-1:0] + MW'(2);
  assign ms2_end = blk_r + ms2[AW-1:0] + AW'(1);
  assign ms3_end = pb_r + ms3[AW-1:0] + AW'(1);

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);
  assign res       = res_r;

  always_comb begin
    a_req = '0;
    b_req = '0;
    case (state_r)
      S_CLR: begin
        a_req.we = 1'b1;
        a_req.waddr = clr_r;
        a_req.wdata = ffha_init_a(clr_r);
        b_req.we = 1'b1;
        b_req.waddr = clr_r;
        b_req.wdata = ffha_init_b(clr_r);
      end
      A_HEAD: begin
        a_req.re = 1'b1;
        a_req.raddr = SENT_LINK;
      end
      A_CHK: begin
        b_req.re = 1'b1;
        b_req.raddr = cur_r;
        a_req.re = 1'b1;
        a_req.raddr = cur_r + AW'(1);
      end
      A_SIZE: begin
        b_req.re = 1'b1;
        b_req.raddr = cur_r + AW'(1);
      end
      F_WALK: begin
        b_req.re = 1'b1;
        b_req.raddr = p_r[AW-1:0];
      end
      F_SIZE: begin
        if (p_r == PW'(blk_r) && b_used) begin
          b_req.we = 1'b1;
          b_req.waddr = blk_r;
          b_req.wdata = {1'b0, b_rdata[MW-1:0]};
          a_req.re = 1'b1;
          a_req.raddr = blk_r;
        end
      end
      F_PHYS: begin
        b_req.re = 1'b1;
        b_req.raddr = a_rdata;
      end
      F_PSZ: begin
        b_req.re = 1'b1;
        b_req.raddr = nb_r;
      end
      F_NSZ: begin
        a_req.re = 1'b1;
        b_req.re = 1'b1;
        b_req.raddr = nb_r + AW'(1);
        if ((pu && nf) || (pf && nf)) begin
          a_req.raddr = nb_r + AW'(1);
        end else begin
          a_req.raddr = SENT_LINK;
        end
      end
      S_WR: begin
        a_req.we = qa_en_r[qi_r];
        a_req.waddr = qa_addr_r[qi_r];
        a_req.wdata = qa_data_r[qi_r];
        b_req.we = qb_en_r[qi_r];
        b_req.waddr = qb_addr_r[qi_r];
        b_req.wdata = qb_data_r[qi_r];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      qi_r <= '0;
      for (int i = 0; i < 4; i++) begin
        qa_en_r[i] <= 1'b0;
        qb_en_r[i] <= 1'b0;
      end
    end else begin
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(ARENA_GRANULES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_r <= MW'(req.request_size);
            cnt_r <= '0;
            p_r <= '0;
            blk_r <= AW'(req.free_address) - AW'(1);
            res_r <= '0;
            qi_r <= '0;
            for (int i = 0; i < 4; i++) begin
              qa_en_r[i] <= 1'b0;
              qb_en_r[i] <= 1'b0;
            end
            if (req.func == FUNC_ALLOC) begin
              state_r <= (req.request_size == '0) ? S_FIN : A_HEAD;
            end else begin
              state_r <= (req.free_address == '0) ? S_FIN : F_WALK;
            end
          end
        end
        A_HEAD: begin
          state_r <= A_HEAD2;
        end
        A_HEAD2: begin
          cur_r <= a_rdata;
          state_r <= A_CHK;
        end
        A_CHK: begin
          if (cnt_r == CW'(ARENA_GRANULES) || cur_r == SENT) begin
            state_r <= S_FIN;
          end else begin
            state_r <= A_SIZE;
          end
        end
        A_SIZE: begin
          cs_r <= b_rdata[MW-1:0];
          ln_r <= a_rdata;
          if (fits) begin
            state_r <= A_PREV;
          end else begin
            cur_r <= a_rdata;
            cnt_r <= cnt_r + CW'(1);
            state_r <= A_CHK;
          end
        end
        A_PREV: begin
          res_r.ok <= 1'b1;
          res_r.payload_address <= FIELD_W'(cur_r + AW'(1));
          state_r <= S_WR;
          if (split) begin
            qa_en_r[0] <= 1'b1; qa_addr_r[0] <= t;                qa_data_r[0] <= cur_r;
            qa_en_r[1] <= 1'b1; qa_addr_r[1] <= t + AW'(1);       qa_data_r[1] <= ln_r;
            qa_en_r[2] <= 1'b1; qa_addr_r[2] <= b_rdata[AW-1:0] + AW'(1);
            qa_data_r[2] <= t;
            qa_en_r[3] <= 1'b1; qa_addr_r[3] <= ts_end;           qa_data_r[3] <= t;
            qb_en_r[0] <= 1'b1; qb_addr_r[0] <= t;                qb_data_r[0] <= {1'b0, ts};
            qb_en_r[1] <= 1'b1; qb_addr_r[1] <= cur_r;            qb_data_r[1] <= {1'b1, req_r};
            qb_en_r[2] <= 1'b1; qb_addr_r[2] <= t + AW'(1);
            qb_data_r[2] <= {2'b00, b_rdata[AW-1:0]};
            qb_en_r[3] <= 1'b1; qb_addr_r[3] <= ln_r + AW'(1);    qb_data_r[3] <= {2'b00, t};
          end else begin
            qa_en_r[0] <= 1'b1; qa_addr_r[0] <= b_rdata[AW-1:0] + AW'(1);
            qa_data_r[0] <= ln_r;
            qb_en_r[0] <= 1'b1; qb_addr_r[0] <= ln_r + AW'(1);
            qb_data_r[0] <= {2'b00, b_rdata[AW-1:0]};
            qb_en_r[1] <= 1'b1; qb_addr_r[1] <= cur_r;            qb_data_r[1] <= {1'b1, cs_r};
          end
        end
        F_WALK: begin
          if (cnt_r == CW'(ARENA_GRANULES) || p_r == PW'(SENT) || p_r > PW'(blk_r)) begin
            state_r <= S_FIN;
          end else begin
            state_r <= F_SIZE;
          end
        end
        F_SIZE: begin
          if (p_r == PW'(blk_r)) begin
            if (b_used) begin
              s_r <= b_rdata[MW-1:0];
              nb_r <= blk_r + b_rdata[AW-1:0] + AW'(1);
              state_r <= F_PHYS;
            end else begin
              state_r <= S_FIN;
            end
          end else begin
            p_r <= p_r + PW'(b_rdata[MW-1:0]) + PW'(1);
            cnt_r <= cnt_r + CW'(1);
            state_r <= F_WALK;
          end
        end
        F_PHYS: begin
          pb_r <= a_rdata;
          state_r <= F_PSZ;
        end
        F_PSZ: begin
          ps_r <= b_rdata;
          state_r <= F_NSZ;
        end
        F_NSZ: begin
          ns_r <= b_rdata;
          res_r.ok <= 1'b1;
          if (pf && nu) begin
            qa_en_r[0] <= 1'b1; qa_addr_r[0] <= nb_r; qa_data_r[0] <= pb_r;
            qb_en_r[0] <= 1'b1; qb_addr_r[0] <= pb_r; qb_data_r[0] <= {1'b0, sz1};
            state_r <= S_WR;
          end else if ((pu && nf) || (pf && nf)) begin
            state_r <= F_LINK;
          end else begin
            state_r <= F_HEAD;
          end
        end
        F_LINK: begin
          state_r <= S_WR;
          if (pu) begin
            qa_en_r[0] <= 1'b1; qa_addr_r[0] <= blk_r + AW'(1);   qa_data_r[0] <= a_rdata;
            qa_en_r[1] <= 1'b1; qa_addr_r[1] <= b_rdata[AW-1:0] + AW'(1);
            qa_data_r[1] <= blk_r;
            qa_en_r[2] <= 1'b1; qa_addr_r[2] <= ms2_end;          qa_data_r[2] <= blk_r;
            qb_en_r[0] <= 1'b1; qb_addr_r[0] <= blk_r + AW'(1);
            qb_data_r[0] <= {2'b00, b_rdata[AW-1:0]};
            qb_en_r[1] <= 1'b1; qb_addr_r[1] <= a_rdata + AW'(1); qb_data_r[1] <= {2'b00, blk_r};
            qb_en_r[2] <= 1'b1; qb_addr_r[2] <= blk_r;            qb_data_r[2] <= {1'b0, ms2};
          end else begin
            qa_en_r[0] <= 1'b1; qa_addr_r[0] <= b_rdata[AW-1:0] + AW'(1);
            qa_data_r[0] <= a_rdata;
            qa_en_r[1] <= 1'b1; qa_addr_r[1] <= ms3_end;          qa_data_r[1] <= pb_r;
            qb_en_r[0] <= 1'b1; qb_addr_r[0] <= a_rdata + AW'(1);
            qb_data_r[0] <= {2'b00, b_rdata[AW-1:0]};
            qb_en_r[1] <= 1'b1; qb_addr_r[1] <= pb_r;             qb_data_r[1] <= {1'b0, ms3};
          end
        end
        F_HEAD: begin
          state_r <= S_WR;
          qa_en_r[0] <= 1'b1; qa_addr_r[0] <= blk_r + AW'(1);     qa_data_r[0] <= a_rdata;
          qa_en_r[1] <= 1'b1; qa_addr_r[1] <= SENT_LINK;          qa_data_r[1] <= blk_r;
          qb_en_r[0] <= 1'b1; qb_addr_r[0] <= blk_r + AW'(1);     qb_data_r[0] <= {2'b00, SENT};
          qb_en_r[1] <= 1'b1; qb_addr_r[1] <= a_rdata + AW'(1);   qb_data_r[1] <= {2'b00, blk_r};
        end
        S_WR: begin
          qi_r <= qi_r + 2'd1;
          if (qi_r == 2'd3) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !idle)
    else $error("sequencer stayed idle after a transfer");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (res.ok || res.payload_address == '0))
    else $error("failed result carries an address");
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> state_r == S_CLR)
    else $error("reset did not start the clearing pass");
  a_wr_only_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> !a_req.re && !b_req.re)
    else $error("read issued during write sequence");
`endif

endmodule

FILE: sv/first_fit_heap_allocator.sv
// First-fit heap allocator over a boundary-tagged arena of ARENA_GRANULES
// granules, sizes and addresses counted in header granules.
// Input channel in_valid/in_ready/in_data: func selects allocate or free;
// request_size is used by an allocate, free_address by a free.
// Result channel out_valid/out_ready/out_data: one result per input
// transfer, in order: payload_address and ok.
// An allocate walks the free list block by block and then writes the links;
// a free walks the physical blocks from granule 0 up to the freed block,
// then reads its neighbours and writes the new links.
// Both walks go one block per step through the arena memory read port.
// At reset a clearing pass writes all ARENA_GRANULES entries, one per
// cycle, building one free block plus the end sentinel;
// in_ready stays low until it finishes.
// A finished result is held in the output register while the receiver
// stalls; a following item may be taken meanwhile, and its result waits
// until the register is free.
module first_fit_heap_allocator import ffha_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ffha_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ffha_out_t out_data
);

  ffha_a_req_t   a_req;
  ffha_b_req_t   b_req;
  logic [AW-1:0] a_rdata;
  logic [BW-1:0] b_rdata;
  logic          idle, res_valid, res_ready;
  ffha_out_t     res;
  logic          out_valid_r;
  ffha_out_t     out_data_r;

  assign in_ready  = idle;
  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  ffha_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && in_ready),
    .req      (in_data),
    .idle     (idle),
    .a_req    (a_req),
    .b_req    (b_req),
    .a_rdata  (a_rdata),
    .b_rdata  (b_rdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  ffha_ram #(.WIDTH(AW), .DEPTH(ARENA_GRANULES)) u_ram_a (
    .clk  (clk),
    .we   (a_req.we),
    .waddr(a_req.waddr),
    .wdata(a_req.wdata),
    .re   (a_req.re),
    .raddr(a_req.raddr),
    .rdata(a_rdata)
  );

  ffha_ram #(.WIDTH(BW), .DEPTH(ARENA_GRANULES)) u_ram_b (
    .clk  (clk),
    .we   (b_req.we),
    .waddr(b_req.waddr),
    .wdata(b_req.wdata),
    .re   (b_req.re),
    .raddr(b_req.raddr),
    .rdata(b_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

endmodule

FILE: sim/tb_first_fit_heap_allocator.sv
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator import ffha_pkg::*; ();

  localparam int NG = ARENA_GRANULES;
  localparam int SENTI = ARENA_GRANULES - 2;
  localparam int CYCLE_LIMIT = 10000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  ffha_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  ffha_out_t out_data;

  first_fit_heap_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // heap image: link word and size word per granule
  int heap_lnk [NG];
  int heap_sz [NG];
  ffha_out_t pending_results[$];
  int live_payloads[$];
  int mismatches;
  int results_seen;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off;

  function automatic int wrap(int i);
    return ((i % NG) + NG) % NG;
  endfunction

  function automatic int blk_size(int b);
    return heap_sz[wrap(b)];
  endfunction

  function automatic void put_size(int b, int s);
    heap_sz[wrap(b)] = s;
  endfunction

  function automatic void put_phys(int b, int p);
    heap_lnk[wrap(b)] = wrap(p);
  endfunction

  function automatic int nxt(int b);
    return heap_lnk[wrap(b + 1)];
  endfunction

  function automatic int prv(int b);
    return heap_sz[wrap(b + 1)];
  endfunction

  function automatic void put_nxt(int b, int n);
    heap_lnk[wrap(b + 1)] = wrap(n);
  endfunction

  function automatic void put_prv(int b, int p);
    heap_sz[wrap(b + 1)] = wrap(p);
  endfunction

  function automatic int span(int s);
    return (s < 0 ? -s : s) + 1;
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < NG; i++) begin
      heap_lnk[i] = 0;
      heap_sz[i] = 0;
    end
    put_phys(0, SENTI);
    put_size(0, NG - 3);
    put_nxt(0, SENTI);
    put_prv(0, SENTI);
    put_phys(SENTI, 0);
    put_size(SENTI, -1);
    put_nxt(SENTI, 0);
    put_prv(SENTI, 0);
  endfunction

  function automatic bit is_used_block(int blk);
    int p;
    p = 0;
    for (int n = 0; n < NG; n++) begin
      if (p == SENTI || p > blk) return 0;
      if (p == blk) return blk_size(p) < 0;
      p += span(blk_size(p));
    end
    return 0;
  endfunction

  function automatic ffha_out_t heap_alloc(int req);
    ffha_out_t r;
    int cur, cs, ln, lp, t, ts;
    r = '0;
    if (req == 0) return r;
    cur = nxt(SENTI);
    for (int n = 0; n < NG && cur != SENTI; n++) begin
      cs = blk_size(cur);
      if (cs >= req) begin
        ln = nxt(cur);
        lp = prv(cur);
        if (cs > req + 2) begin
          t = cur + req + 1;
          ts = cs - req - 1;
          put_phys(t, cur);
          put_size(t, ts);
          put_size(cur, -req);
          put_nxt(t, ln);
          put_prv(t, lp);
          put_prv(ln, t);
          put_nxt(lp, t);
          put_phys(t + ts + 1, t);
        end else begin
          put_prv(ln, lp);
          put_nxt(lp, ln);
          put_size(cur, -cs);
        end
        r.payload_address = 10'(cur + 1);
        r.ok = 1'b1;
        return r;
      end
      cur = nxt(cur);
    end
    return r;
  endfunction

  function automatic bit heap_release(int addr);
    int blk, s, nb, pb, ps, ns, ln, lp, ms, head;
    if (addr == 0) return 0;
    blk = addr - 1;
    if (!is_used_block(blk)) return 0;
    s = -blk_size(blk);
    put_size(blk, s);
    nb = blk + s + 1;
    pb = heap_lnk[wrap(blk)];
    ps = blk_size(pb);
    ns = blk_size(nb);
    if (ps > 0 && ns < 0) begin
      put_size(pb, ps + s + 1);
      put_phys(nb, pb);
    end else if (ps < 0 && ns > 0) begin
      ln = nxt(nb);
      lp = prv(nb);
      ms = s + ns + 1;
      put_nxt(blk, ln);
      put_prv(blk, lp);
      put_nxt(lp, blk);
      put_prv(ln, blk);
      put_size(blk, ms);
      put_phys(blk + ms + 1, blk);
    end else if (ps > 0 && ns > 0) begin
      ln = nxt(nb);
      lp = prv(nb);
      ms = ps + s + ns + 2;
      put_nxt(lp, ln);
      put_prv(ln, lp);
      put_size(pb, ms);
      put_phys(pb + ms + 1, pb);
    end else begin
      head = nxt(SENTI);
      put_nxt(blk, head);
      put_prv(blk, SENTI);
      put_nxt(SENTI, blk);
      put_prv(head, blk);
    end
    return 1;
  endfunction

  function automatic ffha_out_t heap_step(ffha_in_t it);
    ffha_out_t r;
    int idx;
    if (it.func == FUNC_ALLOC) begin
      r = heap_alloc(int'(it.request_size));
      if (r.ok) live_payloads.push_back(int'(r.payload_address));
    end else begin
      r = '0;
      r.ok = heap_release(int'(it.free_address));
      if (r.ok) begin
        idx = -1;
        foreach (live_payloads[i]) if (live_payloads[i] == int'(it.free_address)) idx = i;
        if (idx >= 0) live_payloads.delete(idx);
      end
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("tb_first_fit_heap_allocator: errors");
        $finish;
      end
    end
  end

  // result check at the rising edge
  always @(posedge clk) begin
    ffha_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: expected none, got addr %0d ok %0b",
                   out_data.payload_address, out_data.ok);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr %0d ok %0b, got addr %0d ok %0b",
                     exp_r.payload_address, exp_r.ok,
                     out_data.payload_address, out_data.ok);
        end
      end
    end
  end

  // receiver stall, driven at the falling edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(ffha_in_t it, bit fixed_check, ffha_out_t fixed_r);
    ffha_out_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = heap_step(it);
    if (fixed_check && r !== fixed_r) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row: expected addr %0d ok %0b, predictor gives addr %0d ok %0b",
                 fixed_r.payload_address, fixed_r.ok, r.payload_address, r.ok);
    end
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic ffha_in_t mk(bit f, int rs, int fa);
    ffha_in_t it;
    it.func = f;
    it.request_size = 10'(rs);
    it.free_address = 10'(fa);
    return it;
  endfunction

  function automatic ffha_out_t res(int a, bit k);
    ffha_out_t r;
    r.payload_address = 10'(a);
    r.ok = k;
    return r;
  endfunction

  typedef struct {
    ffha_in_t  item;
    bit        fixed;
    ffha_out_t result;
  } stim_row_t;

  stim_row_t stim_table[$];

  function automatic ffha_in_t random_item();
    int kind;
    kind = $urandom_range(99);
    if (kind < 50) return mk(FUNC_ALLOC, $urandom_range(1, 40), $urandom_range(1023));
    if (kind < 56) return mk(FUNC_ALLOC, $urandom_range(1023), $urandom_range(1023));
    if (kind < 90 && live_payloads.size() != 0)
      return mk(FUNC_FREE, $urandom_range(1023),
                live_payloads[$urandom_range(live_payloads.size() - 1)]);
    return mk(FUNC_FREE, $urandom_range(1023), $urandom_range(1023));
  endfunction

  initial begin
    mismatches = 0;
    results_seen = 0;
    hold_off = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    heap_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    stim_table.push_back('{mk(FUNC_ALLOC, 0, 1023), 1, res(0, 0)});
    stim_table.push_back('{mk(FUNC_FREE, 1023, 0), 1, res(0, 0)});
    stim_table.push_back('{mk(FUNC_ALLOC, 1022, 0), 1, res(0, 0)});
    stim_table.push_back('{mk(FUNC_ALLOC, 4, 0), 1, res(1, 1)});
    stim_table.push_back('{mk(FUNC_FREE, 0, 1), 1, res(0, 1)});
    stim_table.push_back('{mk(FUNC_FREE, 0, 1), 1, res(0, 0)});
    stim_table.push_back('{mk(FUNC_FREE, 0, 1023), 1, res(0, 0)});
    stim_table.push_back('{mk(FUNC_ALLOC, 1021, 0), 1, res(1, 1)});
    stim_table.push_back('{mk(FUNC_ALLOC, 1, 0), 1, res(0, 0)});
    stim_table.push_back('{mk(FUNC_FREE, 0, 1), 1, res(0, 1)});
    stim_table.push_back('{mk(FUNC_ALLOC, 1019, 0), 1, res(1, 1)});
    stim_table.push_back('{mk(FUNC_FREE, 0, 1), 1, res(0, 1)});
    stim_table.push_back('{mk(FUNC_ALLOC, 10, 0), 0, '0});
    stim_table.push_back('{mk(FUNC_ALLOC, 10, 0), 0, '0});
    stim_table.push_back('{mk(FUNC_ALLOC, 10, 0), 0, '0});
    stim_table.push_back('{mk(FUNC_ALLOC, 10, 0), 0, '0});
    stim_table.push_back('{mk(FUNC_FREE, 0, 13), 0, '0});
    stim_table.push_back('{mk(FUNC_FREE, 0, 5), 0, '0});
    stim_table.push_back('{mk(FUNC_FREE, 0, 1), 0, '0});
    stim_table.push_back('{mk(FUNC_FREE, 0, 34), 0, '0});
    stim_table.push_back('{mk(FUNC_FREE, 0, 23), 0, '0});
    stim_table.push_back('{mk(FUNC_ALLOC, 2, 0), 0, '0});
    stim_table.push_back('{mk(FUNC_FREE, 1023, 1022), 0, '0});
    foreach (stim_table[i]) send_item(stim_table[i].item, stim_table[i].fixed,
                                      stim_table[i].result);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        3: begin send_idle_pct = 24; recv_stall_pct = 24; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if (ph == 4) hold_off = 400;
      for (int k = 0; k < 135; k++) send_item(random_item(), 0, '0);
      drain();
    end

    repeat (200) @(negedge clk);
    $display("covered %0d results, %0d live blocks at end, five idle/stall phases",
             results_seen, live_payloads.size());
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tb_first_fit_heap_allocator: clean");
    else
      $display("tb_first_fit_heap_allocator: errors");
    $finish;
  end

endmodule
